### rtl/nes_pkg.sv
// ----------------------------------------------------------------------------
// nes_pkg
// Widths, character codes and the tone table shared by the scheduler.
// ----------------------------------------------------------------------------
package nes_pkg;

    localparam int PERIOD_W = 26;
    localparam int BEATS_W  = 16;
    localparam int OCT_W    = 4;
    localparam int CHAR_W   = 8;
    localparam int FREQ_W   = 31;
    localparam int TIME_W   = 48;
    localparam int TAB_W    = 33;
    localparam int PROD_W   = BEATS_W + PERIOD_W;
    localparam int DUR_W    = PROD_W - 8;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 176;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(500000);
    localparam logic [FREQ_W-1:0]   FREQ_MAX     = {FREQ_W{1'b1}};
    localparam logic [TIME_W-1:0]   TIME_MAX     = {TIME_W{1'b1}};

    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CHAR_C     = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CHAR_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CHAR_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_G     = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_REST  = 8'h72;
    localparam logic [CHAR_W-1:0] CHAR_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CHAR_FLAT  = 8'h62;

    // octave index five in Q.24, one entry per semitone
    function automatic logic [TAB_W-1:0] tone_tab(input logic [3:0] s);
        logic [TAB_W-1:0] v;
        case (s)
            4'd0:    v = 33'd4389348620;
            4'd1:    v = 33'd4650352871;
            4'd2:    v = 33'd4926877243;
            4'd3:    v = 33'd5219844609;
            4'd4:    v = 33'd5530232722;
            4'd5:    v = 33'd5859077472;
            4'd6:    v = 33'd6207476349;
            4'd7:    v = 33'd6576592100;
            4'd8:    v = 33'd6967656617;
            4'd9:    v = 33'd7381975040;
            4'd10:   v = 33'd7820930118;
            4'd11:   v = 33'd8285986824;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/nes_pitch.sv
// ----------------------------------------------------------------------------
// nes_pitch
// Pitch letter, alteration and octave to Q15.16 frequency, rest detect.
// ----------------------------------------------------------------------------
module nes_pitch (
    input  logic [nes_pkg::CHAR_W-1:0] pitch_char,
    input  logic [nes_pkg::CHAR_W-1:0] accidental_char,
    input  logic [nes_pkg::OCT_W-1:0]  octave_number,
    output logic [nes_pkg::FREQ_W-1:0] freq_q16,
    output logic                       rest_flag
);

    logic signed [4:0]            letter_semi;
    logic signed [4:0]            semi;
    logic [4:0]                   oct_idx;
    logic [3:0]                   semi_idx;
    logic [3:0]                   shift;
    logic [nes_pkg::TAB_W:0]      rounded;
    logic [nes_pkg::TAB_W:0]      shifted;

    always_comb
    begin
        case (pitch_char)
            nes_pkg::CHAR_C: letter_semi = 5'sd0;
            nes_pkg::CHAR_D: letter_semi = 5'sd2;
            nes_pkg::CHAR_E: letter_semi = 5'sd4;
            nes_pkg::CHAR_F: letter_semi = 5'sd5;
            nes_pkg::CHAR_G: letter_semi = 5'sd7;
            nes_pkg::CHAR_A: letter_semi = 5'sd9;
            nes_pkg::CHAR_B: letter_semi = 5'sd11;
            default:         letter_semi = -5'sd1;
        endcase

        if (accidental_char == nes_pkg::CHAR_SHARP)
            semi = letter_semi + 5'sd1;
        else if (accidental_char == nes_pkg::CHAR_FLAT)
            semi = letter_semi - 5'sd1;
        else
            semi = letter_semi;

        // semitone stays within -2..12, so the octave moves by one at most
        if (semi < 5'sd0)
        begin
            oct_idx  = {1'b0, octave_number};
            semi_idx = 4'(semi + 5'sd12);
        end
        else if (semi >= 5'sd12)
        begin
            oct_idx  = 5'({1'b0, octave_number} + 5'd2);
            semi_idx = 4'(semi - 5'sd12);
        end
        else
        begin
            oct_idx  = 5'({1'b0, octave_number} + 5'd1);
            semi_idx = semi[3:0];
        end

        shift   = 4'(5'd13 - oct_idx);
        rounded = {1'b0, nes_pkg::tone_tab(semi_idx)}
                + ((nes_pkg::TAB_W+1)'(1) << (shift - 4'd1));
        shifted = rounded >> shift;

        rest_flag = (pitch_char == nes_pkg::CHAR_REST);
        if (rest_flag)
            freq_q16 = '0;
        else if (oct_idx >= 5'd13)
            freq_q16 = nes_pkg::FREQ_MAX;
        else if (shifted > {3'b000, nes_pkg::FREQ_MAX})
            freq_q16 = nes_pkg::FREQ_MAX;
        else
            freq_q16 = shifted[nes_pkg::FREQ_W-1:0];
    end

endmodule

### rtl/note_event_scheduler.sv
// ----------------------------------------------------------------------------
// note_event_scheduler
// Note to frequency conversion with running track time and song length.
// ----------------------------------------------------------------------------
// Accepts one note request per clock when the output is not stalled and
// returns one result per note after the input and result stages. The input stage
// registers the frequency (table lookup and shift) and the duration product
// of beats and beat period; the result stage adds the duration to the track
// time with saturation and updates the song length, which is the only
// feedback path and closes within the result stage. A new beat period should be written
// only while no note is in flight.
module note_event_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nes_pkg::PERIOD_W-1:0]  cfg_wdata,     // beat_period_us
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pitch_char[7:0], accidental_char[15:8], octave_number[19:16],
    // beats_q8[35:20], zero[39:36]
    input  logic [nes_pkg::IN_W-1:0]      s_axis_tdata,
    input  logic                          s_axis_tuser,  // first_in_track
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // freq_q16[30:0], start_us[78:31], end_us[126:79],
    // song_length_us[174:127], zero[175]
    output logic [nes_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic                          m_axis_tuser   // rest_flag
);

    logic [nes_pkg::PERIOD_W-1:0] beat_period_reg;

    logic [nes_pkg::FREQ_W-1:0]   in_freq;
    logic                         in_rest;
    logic [nes_pkg::PROD_W-1:0]   in_prod;

    logic                         s1_valid_reg;
    logic [nes_pkg::FREQ_W-1:0]   s1_freq_reg;
    logic                         s1_rest_reg;
    logic                         s1_first_reg;
    logic [nes_pkg::DUR_W-1:0]    s1_dur_reg;
    logic                         s1_adv;
    logic                         in_acc;

    logic [nes_pkg::TIME_W-1:0]   track_reg;
    logic [nes_pkg::TIME_W-1:0]   longest_reg;
    logic [nes_pkg::TIME_W-1:0]   start_next;
    logic [nes_pkg::TIME_W:0]     sum_next;
    logic [nes_pkg::TIME_W-1:0]   end_next;
    logic [nes_pkg::TIME_W-1:0]   longest_next;

    logic                         out_valid_reg;
    logic [nes_pkg::FREQ_W-1:0]   out_freq_reg;
    logic                         out_rest_reg;
    logic [nes_pkg::TIME_W-1:0]   out_start_reg;
    logic [nes_pkg::TIME_W-1:0]   out_end_reg;
    logic [nes_pkg::TIME_W-1:0]   out_song_reg;

    nes_pitch u_pitch (
        .pitch_char      (s_axis_tdata[7:0]),
        .accidental_char (s_axis_tdata[15:8]),
        .octave_number   (s_axis_tdata[19:16]),
        .freq_q16        (in_freq),
        .rest_flag       (in_rest)
    );

    assign in_prod = nes_pkg::PROD_W'(s_axis_tdata[35:20])
                   * nes_pkg::PROD_W'(beat_period_reg);

    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_period_reg <= nes_pkg::PERIOD_RESET;
        else if (cfg_we)
            beat_period_reg <= cfg_wdata;
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_freq_reg  <= in_freq;
            s1_rest_reg  <= in_rest;
            s1_first_reg <= s_axis_tuser;
            s1_dur_reg   <= in_prod[nes_pkg::PROD_W-1:8];
        end
    end

    // running time
    always_comb
    begin
        start_next = s1_first_reg ? '0 : track_reg;
        sum_next   = {1'b0, start_next} + (nes_pkg::TIME_W+1)'(s1_dur_reg);
        end_next   = sum_next[nes_pkg::TIME_W] ? nes_pkg::TIME_MAX
                                               : sum_next[nes_pkg::TIME_W-1:0];
        longest_next = (end_next > longest_reg) ? end_next : longest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg     <= '0;
            longest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                track_reg   <= end_next;
                longest_reg <= longest_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_freq_reg  <= s1_freq_reg;
            out_rest_reg  <= s1_rest_reg;
            out_start_reg <= start_next;
            out_end_reg   <= end_next;
            out_song_reg  <= longest_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rest_reg;
    assign m_axis_tdata  = {1'b0, out_song_reg, out_end_reg, out_start_reg, out_freq_reg};

    a_end_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_end_reg >= out_start_reg))
        else $error("end time before start time");

    a_song_covers_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_song_reg >= out_end_reg))
        else $error("song length below note end");

    a_rest_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rest_reg) |-> (out_freq_reg == '0))
        else $error("rest with non-zero frequency");

    a_track_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_valid_reg && s1_first_reg) |=> (out_start_reg == '0))
        else $error("track start not at time zero");

endmodule

### dv/note_event_scheduler_tb.sv
// ----------------------------------------------------------------------------
// note_event_scheduler_tb
// Self-checking bench for the note scheduler: notes go in over the request
// stream, and every result is compared field by field with the typed result
// of its table row or else with an in-bench model of pitch to frequency
// conversion, track timing and song length. A short table of notes comes
// first, then random phases with different beat periods and idle/stall
// mixes, then a short run of the longest notes at the largest beat period.
// ----------------------------------------------------------------------------
module note_event_scheduler_tb;

    import nes_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0]  pitch;
        logic [CHAR_W-1:0]  accid;
        logic [OCT_W-1:0]   octave;
        logic [BEATS_W-1:0] beats;
        logic               first;
    } note_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_q16;
        logic              rest_flag;
        logic [TIME_W-1:0] start_us;
        logic [TIME_W-1:0] end_us;
        logic [TIME_W-1:0] song_length_us;
    } event_t;

    typedef struct packed {
        note_t  note;
        logic   typed;
        event_t res;
    } row_t;

    localparam logic [PERIOD_W-1:0] PERIOD_TOP = {PERIOD_W{1'b1}};
    localparam logic [CHAR_W-1:0]   CHAR_X     = 8'h78;
    localparam logic [CHAR_W-1:0]   CHAR_Z     = 8'h7a;
    localparam logic [CHAR_W-1:0]   CHAR_NONE  = 8'h00;

    // octave index five in Q.24, semitone 0 in the lowest slice
    localparam logic [12*TAB_W-1:0] SEMITONE_Q24 = {
        33'd8285986824, 33'd7820930118, 33'd7381975040, 33'd6967656617,
        33'd6576592100, 33'd6207476349, 33'd5859077472, 33'd5530232722,
        33'd5219844609, 33'd4926877243, 33'd4650352871, 33'd4389348620
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [PERIOD_W-1:0]  cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;

    logic [PERIOD_W-1:0]  beat_period;
    logic [TIME_W-1:0]    track_time;
    logic [TIME_W-1:0]    longest_end;
    event_t               expected_events [$];
    row_t                 note_table [$];
    int                   mismatch_count;
    int                   sender_idle_pct;
    int                   receiver_stall_pct;

    note_event_scheduler u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [FREQ_W-1:0] tone_q16(input note_t n);
        int          semi;
        int          midi;
        int          k;
        int          s;
        int          r;
        logic [63:0] v;
        case (n.pitch)
            CHAR_C:  semi = 0;
            CHAR_D:  semi = 2;
            CHAR_E:  semi = 4;
            CHAR_F:  semi = 5;
            CHAR_G:  semi = 7;
            CHAR_A:  semi = 9;
            CHAR_B:  semi = 11;
            default: semi = -1;
        endcase
        if (n.accid == CHAR_SHARP)
            semi = semi + 1;
        else if (n.accid == CHAR_FLAT)
            semi = semi - 1;
        midi = (int'(n.octave) + 1) * 12 + semi;
        k = midi / 12;
        s = midi % 12;
        if (k >= 13)
            return FREQ_MAX;
        r = 13 - k;
        v = (64'(SEMITONE_Q24[s*TAB_W +: TAB_W]) + (64'd1 << (r - 1))) >> r;
        return (v > 64'(FREQ_MAX)) ? FREQ_MAX : v[FREQ_W-1:0];
    endfunction

    // advances track time and song length
    function automatic event_t schedule_note(input note_t n);
        event_t      e;
        logic [63:0] finish;
        e.rest_flag = (n.pitch == CHAR_REST);
        e.freq_q16  = e.rest_flag ? '0 : tone_q16(n);
        e.start_us  = n.first ? '0 : track_time;
        finish = 64'(e.start_us) + ((64'(n.beats) * 64'(beat_period)) >> 8);
        e.end_us = (finish > 64'(TIME_MAX)) ? TIME_MAX : finish[TIME_W-1:0];
        track_time = e.end_us;
        if (e.end_us > longest_end)
            longest_end = e.end_us;
        e.song_length_us = longest_end;
        return e;
    endfunction

    task automatic add_row(input logic [7:0] p, input logic [7:0] a, input logic [3:0] o,
                           input logic [15:0] b, input logic f, input logic typed,
                           input logic [30:0] fq, input logic rs, input logic [47:0] st,
                           input logic [47:0] en, input logic [47:0] sl);
        row_t row;
        row.note  = '{pitch: p, accid: a, octave: o, beats: b, first: f};
        row.typed = typed;
        row.res   = '{freq_q16: fq, rest_flag: rs, start_us: st, end_us: en,
                      song_length_us: sl};
        note_table.push_back(row);
    endtask

    task automatic send_note(input note_t n, input logic typed, input event_t typed_res);
        event_t e;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, n.beats, n.octave, n.accid, n.pitch};
        s_axis_tuser  <= n.first;
        do
            @(posedge clk);
        while (!s_axis_tready);
        e = schedule_note(n);
        expected_events.push_back(typed ? typed_res : e);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        beat_period = value;
    endtask

    function automatic note_t random_note();
        note_t n;
        if ($urandom_range(0, 99) < 85)
        begin
            case ($urandom_range(0, 7))
                0:       n.pitch = CHAR_C;
                1:       n.pitch = CHAR_D;
                2:       n.pitch = CHAR_E;
                3:       n.pitch = CHAR_F;
                4:       n.pitch = CHAR_G;
                5:       n.pitch = CHAR_A;
                6:       n.pitch = CHAR_B;
                default: n.pitch = CHAR_REST;
            endcase
            case ($urandom_range(0, 2))
                0:       n.accid = CHAR_SHARP;
                1:       n.accid = CHAR_FLAT;
                default: n.accid = CHAR_NONE;
            endcase
            n.octave = 4'($urandom_range(0, 9));
        end
        else
        begin
            n.pitch  = 8'($urandom);
            n.accid  = 8'($urandom);
            n.octave = 4'($urandom);
        end
        case ($urandom_range(0, 9))
            0:       n.beats = '0;
            1:       n.beats = '1;
            default: n.beats = 16'($urandom);
        endcase
        n.first = ($urandom_range(0, 9) == 0);
        return n;
    endfunction

    // result side: random stalls and checking
    initial
    begin
        event_t got;
        event_t want;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.freq_q16       = m_axis_tdata[30:0];
                got.rest_flag      = m_axis_tuser;
                got.start_us       = m_axis_tdata[78:31];
                got.end_us         = m_axis_tdata[126:79];
                got.song_length_us = m_axis_tdata[174:127];
                if (expected_events.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: freq %0d rest %0d start %0d end %0d song %0d",
                                 got.freq_q16, got.rest_flag, got.start_us, got.end_us,
                                 got.song_length_us);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch exp: freq %0d rest %0d start %0d end %0d song %0d",
                                     want.freq_q16, want.rest_flag, want.start_us,
                                     want.end_us, want.song_length_us);
                            $display("         got: freq %0d rest %0d start %0d end %0d song %0d",
                                     got.freq_q16, got.rest_flag, got.start_us,
                                     got.end_us, got.song_length_us);
                        end
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        #(20 * 200000);
        $display("note_event_scheduler_tb: done, errors");
        $finish;
    end

    initial
    begin
        note_t n;
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatch_count     = 0;
        beat_period        = PERIOD_RESET;
        track_time         = '0;
        longest_end        = '0;

        // reset state, rests, saturation at the top octave, A4, then untyped edge notes
        add_row(CHAR_REST, CHAR_NONE, 0, 16'h0000, 0, 1, 0, 1, 0, 0, 0);
        add_row(CHAR_REST, CHAR_SHARP, 9, 16'h0100, 0, 1, 0, 1, 0, 500000, 500000);
        add_row(CHAR_C, CHAR_SHARP, 15, 16'h0000, 0, 1, FREQ_MAX, 0, 500000, 500000, 500000);
        add_row(CHAR_A, CHAR_NONE, 4, 16'h0100, 1, 1, 28835840, 0, 0, 500000, 500000);
        add_row(CHAR_B, CHAR_SHARP, 9, 16'h0000, 1, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_X, CHAR_FLAT, 0, 16'h0080, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_NONE, CHAR_NONE, 0, 16'h0001, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_C, CHAR_FLAT, 0, 16'h0002, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_D, CHAR_SHARP, 1, 16'h1234, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_E, CHAR_NONE, 2, 16'h0040, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_F, CHAR_SHARP, 3, 16'h0200, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_G, CHAR_FLAT, 5, 16'h0300, 1, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_A, CHAR_SHARP, 6, 16'h0010, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_B, CHAR_FLAT, 7, 16'h0800, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_C, CHAR_NONE, 11, 16'h0100, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_B, CHAR_NONE, 10, 16'h0100, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_Z, CHAR_SHARP, 8, 16'h0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_REST, CHAR_SHARP, 15, 16'hFFFF, 1, 0, 0, 0, 0, 0, 0);
        add_row(8'hFF, 8'hFF, 15, 16'hFFFF, 1, 0, 0, 0, 0, 0, 0);
        add_row(CHAR_G, CHAR_SHARP, 9, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (note_table[i])
            send_note(note_table[i].note, note_table[i].typed, note_table[i].res);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       write_period(1);
                1:       write_period(PERIOD_TOP);
                2:       write_period(0);
                3:       write_period(60000000);
                4:       write_period(PERIOD_W'($urandom));
                5:       write_period(PERIOD_RESET);
                6:       write_period(PERIOD_W'($urandom_range(1, 60000000)));
                default: write_period(7);
            endcase
            case (phase % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
                default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            endcase
            repeat (110)
                send_note(random_note(), 1'b0, '0);
        end

        // longest notes at the largest period
        write_period(PERIOD_TOP);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < 20; i++)
        begin
            n       = random_note();
            n.beats = '1;
            n.first = (i == 0);
            send_note(n, 1'b0, '0);
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("note_event_scheduler_tb: done, clean");
        else
            $display("note_event_scheduler_tb: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/nes_pkg.sv
rtl/nes_pitch.sv
rtl/note_event_scheduler.sv
dv/note_event_scheduler_tb.sv
